// ===== design/lgs_pkg.sv =====
`timescale 1ns / 1ps

package lgs_pkg;

    // board and cell sizes
    localparam int MAX_WIDTH     = 256;
    localparam int AGE_BITS      = 8;
    localparam int AGE_PORT_BITS = 8;
    localparam int HEIGHT_LIMIT  = 4096;

    // configuration port
    localparam int CFG_W_BITS    = 9;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 1;

    // derived widths
    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int POS_BITS  = (COL_BITS + 1 > CFG_W_BITS) ? COL_BITS + 1 : CFG_W_BITS;
    localparam int CELL_BITS = AGE_BITS + 1;
    localparam int LINE_BITS = 2 * CELL_BITS;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // request queue between front and back
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BOARD_WIDTH  = 1'b0,
        REG_BOARD_HEIGHT = 1'b1
    } t_reg_idx;

    // stored cell: alive in bit 0, age above it
    typedef logic [CELL_BITS-1:0] t_cell;

    // one classified request for the back end
    typedef struct packed {
        t_cell               incoming;
        logic [COL_BITS-1:0] addr;
        logic                emit;
        logic                last;
        logic                top_ok;
        logic                bot_ok;
        logic                left_ok;
        logic                right_ok;
    } t_task;

endpackage

// ===== design/lgs_ram.sv =====
`timescale 1ns / 1ps

module lgs_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port, read returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lgs_front.sv =====
`timescale 1ns / 1ps

module lgs_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cell_alive,
    input  logic [lgs_pkg::AGE_PORT_BITS-1:0] i_cell_age,
    input  logic                              i_is_padding,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [lgs_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                              o_push,
    output lgs_pkg::t_task                    o_task,
    input  logic                              i_full
);

    import lgs_pkg::*;

    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;
    logic [COL_BITS-1:0]   r_col;
    logic [CFG_H_BITS-1:0] r_row;
    logic [COL_BITS-1:0]   n_col;
    logic [CFG_H_BITS-1:0] n_row;

    logic                  accept;
    logic                  cfg_write;
    logic [CFG_H_BITS-1:0] h_plus1;
    logic                  pos_wrap;
    logic [COL_BITS-1:0]   col;
    logic [CFG_H_BITS-1:0] row;
    logic                  emit_end;
    logic                  emit_mid;
    logic                  last;
    logic [POS_BITS-1:0]   col_inc;
    t_task                 req;

    // hold width to 1..MAX_WIDTH
    function automatic logic [CFG_W_BITS-1:0] clamp_width(input logic [CFG_W_BITS-1:0] v);
        logic [CFG_W_BITS-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W_BITS'(1);
        end else if (POS_BITS'(v) > POS_BITS'(MAX_WIDTH)) begin
            res = CFG_W_BITS'(MAX_WIDTH);
        end
        return res;
    endfunction

    // hold height to 1..HEIGHT_LIMIT
    function automatic logic [CFG_H_BITS-1:0] clamp_height(input logic [CFG_H_BITS-1:0] v);
        logic [CFG_H_BITS-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_H_BITS'(1);
        end else if (v > CFG_H_BITS'(HEIGHT_LIMIT)) begin
            res = CFG_H_BITS'(HEIGHT_LIMIT);
        end
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;
    assign o_stall     = i_full;
    assign accept      = i_valid && !i_full;
    assign o_push      = accept;
    assign h_plus1     = r_height + CFG_H_BITS'(1);

    // classify the item by its position
    always_comb begin
        pos_wrap = (POS_BITS'(r_col) >= POS_BITS'(r_width)) || (r_row > h_plus1);
        col      = pos_wrap ? '0 : r_col;
        row      = pos_wrap ? '0 : r_row;
        emit_end = (col == '0) && (row >= CFG_H_BITS'(2));
        emit_mid = (col != '0) && (row >= CFG_H_BITS'(1));
        last     = emit_end && (row == h_plus1);

        req.incoming = '0;
        if (!i_is_padding && (row < r_height)) begin
            req.incoming = {AGE_BITS'(i_cell_age), i_cell_alive};
        end
        req.addr = col;
        req.emit = emit_end || emit_mid;
        req.last = last;
        if (emit_end) begin
            // bottom right of the previous row, before the window moves
            req.top_ok   = (row != CFG_H_BITS'(2));
            req.bot_ok   = (row != h_plus1);
            req.left_ok  = (r_width >= CFG_W_BITS'(2));
            req.right_ok = 1'b0;
        end else begin
            req.top_ok   = (row != CFG_H_BITS'(1));
            req.bot_ok   = (row < r_height);
            req.left_ok  = (col >= COL_BITS'(2));
            req.right_ok = 1'b1;
        end

        // advance the raster position
        col_inc = POS_BITS'(col) + POS_BITS'(1);
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= POS_BITS'(r_width)) begin
            n_col = '0;
            n_row = row + CFG_H_BITS'(1);
        end else begin
            n_col = col_inc[COL_BITS-1:0];
            n_row = row;
        end
    end

    assign o_task = req;

    // configuration registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_width(CFG_W_BITS'(256));
            r_height <= clamp_height(CFG_H_BITS'(256));
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_write) begin
            case (t_reg_idx'(i_cfg_index))
                REG_BOARD_WIDTH: begin
                    r_width <= clamp_width(i_cfg_data[CFG_W_BITS-1:0]);
                end
                REG_BOARD_HEIGHT: begin
                    r_height <= clamp_height(i_cfg_data[CFG_H_BITS-1:0]);
                end
                default: begin
                    r_width <= r_width;
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== design/lgs_queue.sv =====
`timescale 1ns / 1ps

module lgs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lgs_pkg::t_task i_task,
    output logic           o_full,
    output logic           o_valid,
    output lgs_pkg::t_task o_task,
    input  logic           i_pop
);

    import lgs_pkg::*;

    t_task                     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;

    function automatic logic [QUEUE_PTR_BITS-1:0] ptr_inc(input logic [QUEUE_PTR_BITS-1:0] p);
        logic [QUEUE_PTR_BITS-1:0] res;
        res = p + QUEUE_PTR_BITS'(1);
        if (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end
        return res;
    endfunction

    assign o_full  = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_task  = r_mem[r_rd_ptr];

    // request storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QUEUE_CNT_BITS'(1);
            end
        end
    end

endmodule

// ===== design/lgs_back.sv =====
`timescale 1ns / 1ps

module lgs_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  lgs_pkg::t_task                    i_q_task,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_next_alive,
    output logic [lgs_pkg::AGE_PORT_BITS-1:0] o_next_age,
    output logic                              o_last_of_frame
);

    import lgs_pkg::*;

    t_task                r_b;
    logic                 r_b_valid;
    logic                 r_byp;
    logic [LINE_BITS-1:0] r_byp_data;
    t_cell                r_win_l [3];
    t_cell                r_win_c [3];
    logic                 r_out_valid;
    logic                 r_out_alive;
    logic [AGE_BITS-1:0]  r_out_age;
    logic                 r_out_last;

    logic                 out_free;
    logic                 b_adv;
    logic                 pop;
    logic [LINE_BITS-1:0] ram_rdata;
    logic [LINE_BITS-1:0] line_q;
    logic [LINE_BITS-1:0] ram_wdata;
    t_cell                fresh [3];
    logic [7:0]           nb;
    logic [3:0]           n_count;
    t_cell                centre;
    logic [AGE_BITS-1:0]  centre_age;
    logic                 n_alive;
    logic [AGE_BITS-1:0]  n_age;

    // handshake between queue, window stage and output register
    assign out_free = !r_out_valid || !i_stall;
    assign b_adv    = r_b_valid && (!r_b.emit || out_free);
    assign pop      = i_q_valid && (!r_b_valid || b_adv);
    assign o_pop    = pop;

    // both line stores in one memory: upper row above, middle row below
    lgs_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (b_adv),
        .i_waddr (r_b.addr),
        .i_wdata (ram_wdata),
        .i_re    (pop),
        .i_raddr (i_q_task.addr),
        .o_rdata (ram_rdata)
    );

    // forward a write that hit the same column as the read
    assign line_q    = r_byp ? r_byp_data : ram_rdata;
    assign ram_wdata = {line_q[CELL_BITS-1:0], r_b.incoming};

    assign fresh[0] = line_q[LINE_BITS-1:CELL_BITS];
    assign fresh[1] = line_q[CELL_BITS-1:0];
    assign fresh[2] = r_b.incoming;

    // neighbor count and B3/S23 rule
    always_comb begin
        nb[0] = r_win_l[0][0] && r_b.left_ok && r_b.top_ok;
        nb[1] = r_win_l[1][0] && r_b.left_ok;
        nb[2] = r_win_l[2][0] && r_b.left_ok && r_b.bot_ok;
        nb[3] = r_win_c[0][0] && r_b.top_ok;
        nb[4] = r_win_c[2][0] && r_b.bot_ok;
        nb[5] = fresh[0][0] && r_b.right_ok && r_b.top_ok;
        nb[6] = fresh[1][0] && r_b.right_ok;
        nb[7] = fresh[2][0] && r_b.right_ok && r_b.bot_ok;
        n_count    = 4'($countones(nb));
        centre     = r_win_c[1];
        centre_age = centre[CELL_BITS-1:1];
        n_alive    = 1'b0;
        n_age      = '0;
        if (centre[0]) begin
            if ((n_count == 4'd2) || (n_count == 4'd3)) begin
                n_alive = 1'b1;
                n_age   = (centre_age == AGE_MAX) ? AGE_MAX : centre_age + AGE_BITS'(1);
            end
        end else if (n_count == 4'd3) begin
            n_alive = 1'b1;
        end
    end

    // window stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_byp     <= 1'b0;
        end else begin
            if (pop) begin
                r_b_valid <= 1'b1;
                r_byp     <= b_adv && (i_q_task.addr == r_b.addr);
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // window stage payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b        <= i_q_task;
            r_byp_data <= ram_wdata;
        end
    end

    // two most recent window columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win_l[k] <= '0;
                r_win_c[k] <= '0;
            end
        end else if (b_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_win_l[k] <= r_win_c[k];
                r_win_c[k] <= fresh[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_adv && r_b.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv && r_b.emit) begin
            r_out_alive <= n_alive;
            r_out_age   <= n_age;
            r_out_last  <= r_b.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_next_alive    = r_out_alive;
    assign o_next_age      = AGE_PORT_BITS'(r_out_age);
    assign o_last_of_frame = r_out_last;

endmodule

// ===== design/life_generation_stencil.sv =====
`timescale 1ns / 1ps

// Life generation stencil, rule B3/S23, board edges do not wrap.
// Input channel (i_valid / o_stall): one cell per request in raster order,
// alive bit and age; after each frame the source sends board_width+1
// padding requests to flush the last row.
// Output channel (o_valid / i_stall): next generation of the cell one row
// plus one cell behind the input; o_last_of_frame marks the bottom right cell.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 board_width, index 1
// board_height; any write restarts the frame position. Write only when idle.
// Throughput: one cell per clock while the receiver does not stall, set by
// the line memory that is read and rewritten once per cell.
// Path: an accepted request waits in the queue slot, then passes the line
// memory read, window and rule; the result is registered onto o_valid.
// Reset: position (0, 0), width and height 256, pipeline empty; the line
// memory is not cleared, entries outside the board are masked.
// Receiver stall: the output register holds; a two-entry request queue
// fills, and o_stall rises once it is full.
module life_generation_stencil (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cell_alive,
    input  logic [lgs_pkg::AGE_PORT_BITS-1:0] i_cell_age,
    input  logic                              i_is_padding,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_next_alive,
    output logic [lgs_pkg::AGE_PORT_BITS-1:0] o_next_age,
    output logic                              o_last_of_frame,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [lgs_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    import lgs_pkg::*;

    logic  push;
    t_task push_task;
    logic  q_full;
    logic  q_valid;
    t_task q_task;
    logic  pop;

    // position tracking and classification
    lgs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cell_alive (i_cell_alive),
        .i_cell_age   (i_cell_age),
        .i_is_padding (i_is_padding),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_task       (push_task),
        .i_full       (q_full)
    );

    // request queue
    lgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (push_task),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_task  (q_task),
        .i_pop   (pop)
    );

    // line memory, window and rule
    lgs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_task        (q_task),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_next_alive    (o_next_alive),
        .o_next_age      (o_next_age),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== design/lgs_checker.sv =====
`timescale 1ns / 1ps

module lgs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_next_alive,
    input logic [lgs_pkg::AGE_PORT_BITS-1:0] o_next_age,
    input logic                              o_last_of_frame
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // reset empties the request queue
    a_reset_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stall after reset");

    // the queue only fills through an accepted request
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("input stall without an accepted request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_next_alive)
            && $stable(o_next_age) && $stable(o_last_of_frame))
        else $error("stalled result changed");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (.*);
